[src/psior_pkg.sv]
// ----------------------------------------------------------------------------
// psior_pkg
// Shared types and constants of the per-source in-order release unit.
// ----------------------------------------------------------------------------
package psior_pkg;

  localparam int unsigned SOURCE_W = 4;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned TAG_W    = 16;

  localparam int unsigned DEF_SOURCES = 16;
  localparam int unsigned DEF_WINDOW  = 32;

  typedef struct packed {
    logic [SOURCE_W-1:0] source;
    logic [SEQ_W-1:0]    min_unfinished;
    logic [SEQ_W-1:0]    seq_no;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    req_tag;
  } req_t;

  typedef struct packed {
    logic [SOURCE_W-1:0] out_source;
    logic [SEQ_W-1:0]    out_seq_no;
    logic [HANDLE_W-1:0] out_handle;
    logic [TAG_W-1:0]    out_req_tag;
    logic                last;
  } rel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAISE,
    ST_STORE,
    ST_WALK,
    ST_LOAD,
    ST_WB
  } state_t;

endpackage

[src/psior_state_mem.sv]
// ----------------------------------------------------------------------------
// psior_state_mem
// Per-source state row memory: expected sequence, window pointer, slot mask.
// Rows never written read back as zero.
// ----------------------------------------------------------------------------
module psior_state_mem #(
  parameter int unsigned DEPTH = psior_pkg::DEF_SOURCES,
  parameter int unsigned ROW_W = psior_pkg::SEQ_W + $clog2(psior_pkg::DEF_WINDOW)
                                 + psior_pkg::DEF_WINDOW,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [ROW_W-1:0] rd_q;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= row_valid[rd_idx];
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule

[src/psior_handle_mem.sv]
// ----------------------------------------------------------------------------
// psior_handle_mem
// Slot handle memory, one entry per source and window slot.
// ----------------------------------------------------------------------------
module psior_handle_mem #(
  parameter int unsigned DEPTH  = psior_pkg::DEF_SOURCES * psior_pkg::DEF_WINDOW,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [psior_pkg::HANDLE_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [psior_pkg::HANDLE_W-1:0] wr_data
);

  import psior_pkg::*;

  logic [HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/per_source_in_order_release_unit.sv]
// ----------------------------------------------------------------------------
// per_source_in_order_release_unit
// Reorder buffer releasing each source's requests strictly in sequence order.
// ----------------------------------------------------------------------------
// One request at a time. A request that releases nothing steps through accept,
// raise, store, one empty walk probe and state write-back; one that releases
// requests takes a walk and a load step for each, in place of the empty probe,
// and the load step waits while the release side stalls. A request whose
// source is out of range returns to idle after raise. A run releases at most
// WINDOW requests, walking the window one slot per handle memory read.
// Per-source state sits in a row memory with a valid flop per row, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module per_source_in_order_release_unit #(
  parameter int unsigned SOURCES = psior_pkg::DEF_SOURCES,
  parameter int unsigned WINDOW  = psior_pkg::DEF_WINDOW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  psior_pkg::req_t req,
  output logic            rel_valid,
  input  logic            rel_stall,
  output psior_pkg::rel_t rel
);

  import psior_pkg::*;

  localparam int unsigned SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned ADDR_W = $clog2(SOURCES * WINDOW);
  localparam int unsigned ROW_W  = SEQ_W + PTR_W + WINDOW;

  function automatic logic [PTR_W-1:0] add_mod(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(WINDOW)) begin
      s = s - (PTR_W+1)'(WINDOW);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRC_W-1:0] idx,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(idx) * ADDR_W'(WINDOW) + ADDR_W'(p);
  endfunction

  state_t state, state_next;

  req_t                req_q;
  logic [SEQ_W-1:0]    exp_seq;
  logic [PTR_W-1:0]    ptr;
  logic [WINDOW-1:0]   mask;
  logic [SEQ_W-1:0]    rel_seq;
  logic                rel_last;

  logic [SRC_W+SOURCE_W-1:0] src_wide_in, src_wide_q;
  logic [SRC_W-1:0]    src_idx_in, src_idx;
  logic                src_ok_in, src_ok;

  logic                accept;
  logic                smem_rd_en, smem_wr_en;
  logic [ROW_W-1:0]    smem_rd_data, smem_wr_data;
  logic                hmem_rd_en, hmem_wr_en;
  logic [ADDR_W-1:0]   hmem_rd_addr, hmem_wr_addr;
  logic [HANDLE_W-1:0] hmem_rd_data;

  logic [SEQ_W-1:0]    row_exp;
  logic [PTR_W-1:0]    row_ptr;
  logic [WINDOW-1:0]   row_mask;
  logic [SEQ_W-1:0]    gap;
  logic                raise;
  logic [SEQ_W-1:0]    raise_exp;
  logic [PTR_W-1:0]    raise_ptr;
  logic [WINDOW-1:0]   raise_mask;

  logic [SEQ_W-1:0]    seq_off;
  logic                in_window;
  logic [PTR_W-1:0]    slot;
  logic                do_store;

  logic                cur_set;
  logic [PTR_W-1:0]    ptr_inc;
  logic [WINDOW-1:0]   mask_clr;
  logic                out_free;

  assign src_wide_in = {SRC_W'(0), req.source};
  assign src_idx_in  = src_wide_in[SRC_W-1:0];
  assign src_ok_in   = src_wide_in < (SRC_W+SOURCE_W)'(SOURCES);
  assign src_wide_q  = {SRC_W'(0), req_q.source};
  assign src_idx     = src_wide_q[SRC_W-1:0];
  assign src_ok      = src_wide_q < (SRC_W+SOURCE_W)'(SOURCES);

  assign accept = req_valid && !req_stall;

  psior_state_mem #(
    .DEPTH (SOURCES),
    .ROW_W (ROW_W),
    .IDX_W (SRC_W)
  ) u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (smem_rd_en),
    .rd_idx  (src_idx_in),
    .rd_data (smem_rd_data),
    .wr_en   (smem_wr_en),
    .wr_idx  (src_idx),
    .wr_data (smem_wr_data)
  );

  psior_handle_mem #(
    .DEPTH  (SOURCES * WINDOW),
    .ADDR_W (ADDR_W)
  ) u_handle_mem (
    .clk     (clk),
    .rd_en   (hmem_rd_en),
    .rd_addr (hmem_rd_addr),
    .rd_data (hmem_rd_data),
    .wr_en   (hmem_wr_en),
    .wr_addr (hmem_wr_addr),
    .wr_data (req_q.handle)
  );

  // raise: clear slots below the new expected number
  assign {row_exp, row_ptr, row_mask} = smem_rd_data;
  assign gap   = req_q.min_unfinished - row_exp;
  assign raise = req_q.min_unfinished > row_exp;

  always_comb begin
    logic [PTR_W:0] ii;
    logic [PTR_W:0] pp;
    logic [PTR_W:0] off;
    ii         = '0;
    pp         = '0;
    off        = '0;
    raise_exp  = row_exp;
    raise_ptr  = row_ptr;
    raise_mask = row_mask;
    if (raise) begin
      raise_exp = req_q.min_unfinished;
      if (gap >= SEQ_W'(WINDOW)) begin
        raise_mask = '0;
      end else begin
        raise_ptr = add_mod(row_ptr, gap[PTR_W-1:0]);
        pp = {1'b0, row_ptr};
        for (int i = 0; i < int'(WINDOW); i++) begin
          ii = (PTR_W+1)'(i);
          off = (ii >= pp) ? (ii - pp) : (ii + (PTR_W+1)'(WINDOW) - pp);
          if (off < gap[PTR_W:0]) begin
            raise_mask[i] = 1'b0;
          end
        end
      end
    end
  end

  // store: first copy wins
  assign seq_off   = req_q.seq_no - exp_seq;
  assign in_window = seq_off < SEQ_W'(WINDOW);
  assign slot      = add_mod(ptr, seq_off[PTR_W-1:0]);
  assign do_store  = in_window && !mask[slot];

  // walk
  assign cur_set  = mask[ptr];
  assign ptr_inc  = add_mod(ptr, PTR_W'(1));
  always_comb begin
    mask_clr      = mask;
    mask_clr[ptr] = 1'b0;
  end
  assign out_free = !rel_valid || !rel_stall;

  assign hmem_rd_addr = slot_addr(src_idx, ptr);
  assign hmem_wr_addr = slot_addr(src_idx, slot);
  assign smem_wr_data = {exp_seq, ptr, mask};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_RAISE;
      ST_RAISE: state_next = src_ok ? ST_STORE : ST_IDLE;
      ST_STORE: state_next = ST_WALK;
      ST_WALK:  state_next = cur_set ? ST_LOAD : ST_WB;
      ST_LOAD:  if (out_free) state_next = rel_last ? ST_WB : ST_WALK;
      ST_WB:    state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    smem_rd_en = 1'b0;
    smem_wr_en = 1'b0;
    hmem_rd_en = 1'b0;
    hmem_wr_en = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        smem_rd_en = req_valid && src_ok_in;
      end
      ST_STORE: hmem_wr_en = do_store;
      ST_WALK:  hmem_rd_en = cur_set;
      ST_WB:    smem_wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) req_q <= req;
      end
      ST_RAISE: begin
        exp_seq <= raise_exp;
        ptr     <= raise_ptr;
        mask    <= raise_mask;
      end
      ST_STORE: begin
        if (do_store) mask[slot] <= 1'b1;
      end
      ST_WALK: begin
        if (cur_set) begin
          rel_seq  <= exp_seq;
          rel_last <= !mask_clr[ptr_inc];
          mask     <= mask_clr;
          ptr      <= ptr_inc;
          exp_seq  <= exp_seq + SEQ_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_valid <= 1'b0;
    end else if (state == ST_LOAD && out_free) begin
      rel_valid <= 1'b1;
    end else if (!rel_stall) begin
      rel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      rel.out_source  <= req_q.source;
      rel.out_seq_no  <= rel_seq;
      rel.out_handle  <= hmem_rd_data;
      rel.out_req_tag <= req_q.req_tag;
      rel.last        <= rel_last;
    end
  end

endmodule
